### hdl/abpp_pkg.sv
// Package for the alpha blend pixel packer: config types, register codes, channel helpers.
`default_nettype none

package abpp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned PixW     = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED_SHIFT   = 3'd0,
    REG_RED_BITS    = 3'd1,
    REG_GREEN_SHIFT = 3'd2,
    REG_GREEN_BITS  = 3'd3,
    REG_BLUE_SHIFT  = 3'd4,
    REG_BLUE_BITS   = 3'd5,
    REG_THREE_BYTE  = 3'd6
  } abpp_reg_e;

  typedef struct packed {
    logic [4:0] red_shift;
    logic [3:0] red_bits;
    logic [4:0] green_shift;
    logic [3:0] green_bits;
    logic [4:0] blue_shift;
    logic [3:0] blue_bits;
    logic       three_byte_mode;
  } abpp_cfg_t;

  localparam logic [7:0] AlphaFull = 8'd255;

  // widths above eight count as eight
  function automatic logic [3:0] eff_bits(logic [3:0] bits);
    return (bits > 4'd8) ? 4'd8 : bits;
  endfunction

  function automatic logic [7:0] unpack_chan(logic [31:0] word, logic [4:0] shift,
                                             logic [3:0] bits);
    logic [3:0]  n;
    logic [31:0] f;
    logic [7:0]  fld;
    n   = eff_bits(bits);
    f   = word >> shift;
    fld = f[7:0] & ~(8'hFF << n);
    if (n == 4'd0) begin
      return 8'd0;
    end
    return fld << (4'd8 - n);
  endfunction

  function automatic logic [31:0] pack_chan(logic [7:0] v, logic [4:0] shift,
                                            logic [3:0] bits);
    logic [3:0] n;
    logic [7:0] f;
    n = eff_bits(bits);
    f = v >> (4'd8 - n);
    if (n == 4'd0) begin
      return 32'd0;
    end
    return {24'd0, f} << shift;
  endfunction

  // floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

### hdl/abpp_cfg_regs.sv
// Configuration register file for the alpha blend pixel packer.
`default_nettype none

module abpp_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [abpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [abpp_pkg::CfgDataW-1:0] cfg_data_i,
  output abpp_pkg::abpp_cfg_t                cfg_o
);

  abpp_pkg::abpp_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        abpp_pkg::REG_RED_SHIFT:   cfg_d.red_shift       = cfg_data_i[4:0];
        abpp_pkg::REG_RED_BITS:    cfg_d.red_bits        = cfg_data_i[3:0];
        abpp_pkg::REG_GREEN_SHIFT: cfg_d.green_shift     = cfg_data_i[4:0];
        abpp_pkg::REG_GREEN_BITS:  cfg_d.green_bits      = cfg_data_i[3:0];
        abpp_pkg::REG_BLUE_SHIFT:  cfg_d.blue_shift      = cfg_data_i[4:0];
        abpp_pkg::REG_BLUE_BITS:   cfg_d.blue_bits       = cfg_data_i[3:0];
        abpp_pkg::REG_THREE_BYTE:  cfg_d.three_byte_mode = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.red_shift       <= 5'd16;
      cfg_q.red_bits        <= 4'd8;
      cfg_q.green_shift     <= 5'd8;
      cfg_q.green_bits      <= 4'd8;
      cfg_q.blue_shift      <= 5'd0;
      cfg_q.blue_bits       <= 4'd8;
      cfg_q.three_byte_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config channel not ready");

  a_cfg_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown(cfg_q))
    else $error("config register unknown");

  a_cfg_mode_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && cfg_index_i == abpp_pkg::REG_THREE_BYTE
      |=> cfg_q.three_byte_mode == $past(cfg_data_i[0]))
    else $error("three_byte_mode transfer not taken");

endmodule

`default_nettype wire

### hdl/alpha_blend_pixel_packer_top.sv
// Top level of the alpha blend pixel packer: three-stage blend pipeline.
// Each accepted input passes through the unpack, multiply-add and divide/pack stage registers in order.
// Throughput: one pixel per cycle while out_stall_i is low.
// Stages advance independently, so bubbles are squeezed out under output stall.
// Reset: config returns to 8:8:8 at 16/8/0, 32-bit mode; pipeline emptied.
`default_nettype none

module alpha_blend_pixel_packer_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [abpp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [abpp_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    src_red_i,
  input  wire logic [7:0]                    src_green_i,
  input  wire logic [7:0]                    src_blue_i,
  input  wire logic [7:0]                    src_alpha_i,
  input  wire logic [31:0]                   dest_pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               write_pixel_o,
  output logic [31:0]                        out_pixel_o
);

  abpp_pkg::abpp_cfg_t cfg;

  abpp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_stall_o = !en1;

  // stage 1: unpack destination
  logic [7:0] sr_q, sg_q, sb_q, a_q, dr_q, dg_q, db_q;
  logic [31:0] dest_m;
  always_comb begin
    dest_m = dest_pixel_i;
    if (cfg.three_byte_mode) begin
      dest_m[31:24] = 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      sr_q <= src_red_i;
      sg_q <= src_green_i;
      sb_q <= src_blue_i;
      a_q  <= src_alpha_i;
      dr_q <= abpp_pkg::unpack_chan(dest_m, cfg.red_shift, cfg.red_bits);
      dg_q <= abpp_pkg::unpack_chan(dest_m, cfg.green_shift, cfg.green_bits);
      db_q <= abpp_pkg::unpack_chan(dest_m, cfg.blue_shift, cfg.blue_bits);
    end
  end

  // stage 2: s*a + d*(255-a); alpha 255 reduces to s*255
  logic [7:0]  na;
  logic [15:0] sum_r_q, sum_g_q, sum_b_q;
  logic        azero_q;
  assign na = abpp_pkg::AlphaFull - a_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      sum_r_q <= 16'(sr_q) * 16'(a_q) + 16'(dr_q) * 16'(na);
      sum_g_q <= 16'(sg_q) * 16'(a_q) + 16'(dg_q) * 16'(na);
      sum_b_q <= 16'(sb_q) * 16'(a_q) + 16'(db_q) * 16'(na);
      azero_q <= (a_q == 8'd0);
    end
  end

  // stage 3: divide by 255, repack; alpha 0 gives a zero pixel and no write
  logic [31:0] px;
  always_comb begin
    px = abpp_pkg::pack_chan(abpp_pkg::div255(sum_r_q), cfg.red_shift, cfg.red_bits)
       | abpp_pkg::pack_chan(abpp_pkg::div255(sum_g_q), cfg.green_shift, cfg.green_bits)
       | abpp_pkg::pack_chan(abpp_pkg::div255(sum_b_q), cfg.blue_shift, cfg.blue_bits);
    if (cfg.three_byte_mode) begin
      px[31:24] = 8'd0;
    end
    if (azero_q) begin
      px = 32'd0;
    end
  end

  logic        wr_q;
  logic [31:0] px_q;
  always_ff @(posedge clk_i) begin
    if (en3) begin
      wr_q <= !azero_q;
      px_q <= px;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign out_valid_o   = v3_q;
  assign write_pixel_o = wr_q;
  assign out_pixel_o   = px_q;

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !write_pixel_o |-> out_pixel_o == 32'd0)
    else $error("no-write result carries a nonzero pixel");

  a_24bit_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cfg.three_byte_mode |-> out_pixel_o[31:24] == 8'd0)
    else $error("24-bit result has top byte set");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> v1_q && v2_q && v3_q && out_stall_i)
    else $error("input stalled while pipeline has room");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && out_stall_i |=> v3_q && $stable(px_q) && $stable(wr_q))
    else $error("stalled result changed");

endmodule

`default_nettype wire

### sim/tb.sv
`timescale 1ns / 1ps
// Testbench for alpha_blend_pixel_packer_top: directed table, then random blends against a predictor.
module tb;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned NumPhases  = 18;
  localparam int unsigned PhaseItems = 48;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned TailCycles = 8;
  localparam logic [abpp_pkg::CfgIdxW-1:0] RegSpare = 3'd7;

  typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_e;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [31:0] dest;
  } pixel_in_t;

  typedef struct packed {
    logic        write;
    logic [31:0] pixel;
  } pixel_out_t;

  typedef struct packed {
    row_kind_e                      kind;
    logic [abpp_pkg::CfgIdxW-1:0]   reg_idx;
    logic [abpp_pkg::CfgDataW-1:0]  reg_data;
    pixel_in_t                      px;
    logic                           known;
    pixel_out_t                     want;
  } stim_row_t;

  logic                          clk_i        = 1'b0;
  logic                          rst_ni       = 1'b0;
  logic                          cfg_valid_i  = 1'b0;
  logic                          cfg_ready_o;
  logic [abpp_pkg::CfgIdxW-1:0]  cfg_index_i  = '0;
  logic [abpp_pkg::CfgDataW-1:0] cfg_data_i   = '0;
  logic                          in_valid_i   = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    src_red_i    = '0;
  logic [7:0]                    src_green_i  = '0;
  logic [7:0]                    src_blue_i   = '0;
  logic [7:0]                    src_alpha_i  = '0;
  logic [31:0]                   dest_pixel_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i  = 1'b0;
  logic                          write_pixel_o;
  logic [31:0]                   out_pixel_o;

  abpp_pkg::abpp_cfg_t live_cfg = '{5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8, 1'b0};
  pixel_out_t  pending_pixels[$];
  stim_row_t   directed_rows[21];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned send_pct       = 35;
  int unsigned recv_pct       = 57;
  int unsigned hold_left      = 0;
  logic        hold_wanted    = 1'b0;

  alpha_blend_pixel_packer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .src_red_i     (src_red_i),
    .src_green_i   (src_green_i),
    .src_blue_i    (src_blue_i),
    .src_alpha_i   (src_alpha_i),
    .dest_pixel_i  (dest_pixel_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .write_pixel_o (write_pixel_o),
    .out_pixel_o   (out_pixel_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // device field -> 8-bit channel, MSB aligned
  function automatic logic [7:0] field_in(logic [31:0] word, logic [4:0] shift,
                                          logic [3:0] bits);
    int unsigned n;
    logic [31:0] f;
    n = (bits > 4'd8) ? 8 : int'(bits);
    if (n == 0) return 8'd0;
    f = (word >> shift) & ((32'd1 << n) - 32'd1);
    return 8'(f << (8 - n));
  endfunction

  // 8-bit channel -> device field, bits past 31 dropped
  function automatic logic [31:0] field_out(logic [7:0] v, logic [4:0] shift,
                                            logic [3:0] bits);
    int unsigned n;
    logic [63:0] f;
    n = (bits > 4'd8) ? 8 : int'(bits);
    if (n == 0) return 32'd0;
    f = 64'(v >> (8 - n));
    return 32'(f << shift);
  endfunction

  function automatic logic [7:0] mix_chan(logic [7:0] s, logic [7:0] d, logic [7:0] a);
    int unsigned acc;
    acc = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return 8'(acc / 255);
  endfunction

  function automatic pixel_out_t blended_pixel(abpp_pkg::abpp_cfg_t c, pixel_in_t p);
    pixel_out_t  r;
    logic [31:0] dest;
    logic [7:0]  dr, dg, db;
    r = '0;
    if (p.alpha == 8'd0) return r;
    dest = c.three_byte_mode ? {8'd0, p.dest[23:0]} : p.dest;
    if (p.alpha == abpp_pkg::AlphaFull) begin
      r.pixel = field_out(p.red, c.red_shift, c.red_bits)
              | field_out(p.green, c.green_shift, c.green_bits)
              | field_out(p.blue, c.blue_shift, c.blue_bits);
    end else begin
      dr = field_in(dest, c.red_shift, c.red_bits);
      dg = field_in(dest, c.green_shift, c.green_bits);
      db = field_in(dest, c.blue_shift, c.blue_bits);
      r.pixel = field_out(mix_chan(p.red, dr, p.alpha), c.red_shift, c.red_bits)
              | field_out(mix_chan(p.green, dg, p.alpha), c.green_shift, c.green_bits)
              | field_out(mix_chan(p.blue, db, p.alpha), c.blue_shift, c.blue_bits);
    end
    if (c.three_byte_mode) r.pixel[31:24] = 8'd0;
    r.write = 1'b1;
    return r;
  endfunction

  function automatic stim_row_t pix_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                        logic [7:0] a, logic [31:0] dest);
    return '{ROW_PIXEL, '0, '0, '{r, g, b, a, dest}, 1'b0, '0};
  endfunction

  function automatic stim_row_t known_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                          logic [7:0] a, logic [31:0] dest,
                                          logic wr, logic [31:0] pixel);
    return '{ROW_PIXEL, '0, '0, '{r, g, b, a, dest}, 1'b1, '{wr, pixel}};
  endfunction

  function automatic stim_row_t reg_row(logic [abpp_pkg::CfgIdxW-1:0] idx,
                                        logic [abpp_pkg::CfgDataW-1:0] data);
    return '{ROW_REG, idx, data, '0, 1'b0, '0};
  endfunction

  function automatic logic [31:0] pad_upper(logic [31:0] v, int unsigned w);
    return v | ($urandom() << w);
  endfunction

  function automatic logic [3:0] chan_width();
    return ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
  endfunction

  // leaves valid high; the next send_pixel call lowers it
  task automatic write_reg(input logic [abpp_pkg::CfgIdxW-1:0] idx,
                           input logic [abpp_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic send_pixel(input pixel_in_t px, input logic known, input pixel_out_t want);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    src_red_i    <= px.red;
    src_green_i  <= px.green;
    src_blue_i   <= px.blue;
    src_alpha_i  <= px.alpha;
    dest_pixel_i <= px.dest;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_pixels.push_back(known ? want : blended_pixel(live_cfg, px));
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        abpp_pkg::REG_RED_SHIFT:   live_cfg.red_shift       <= cfg_data_i[4:0];
        abpp_pkg::REG_RED_BITS:    live_cfg.red_bits        <= cfg_data_i[3:0];
        abpp_pkg::REG_GREEN_SHIFT: live_cfg.green_shift     <= cfg_data_i[4:0];
        abpp_pkg::REG_GREEN_BITS:  live_cfg.green_bits      <= cfg_data_i[3:0];
        abpp_pkg::REG_BLUE_SHIFT:  live_cfg.blue_shift      <= cfg_data_i[4:0];
        abpp_pkg::REG_BLUE_BITS:   live_cfg.blue_bits       <= cfg_data_i[3:0];
        abpp_pkg::REG_THREE_BYTE:  live_cfg.three_byte_mode <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : check_out
    pixel_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected transfer: write_pixel %0d, out_pixel %h",
               write_pixel_o, out_pixel_o);
        mismatch_count++;
      end else begin
        want = pending_pixels.pop_front();
        if (write_pixel_o !== want.write) begin
          $error("write_pixel: expected %0d, got %0d", want.write, write_pixel_o);
          mismatch_count++;
        end
        if (out_pixel_o !== want.pixel) begin
          $error("out_pixel: expected %h, got %h", want.pixel, out_pixel_o);
          mismatch_count++;
        end
      end
    end
  end

  // receiver back-pressure, with a long hold-off when requested
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_wanted) begin
      hold_wanted = 1'b0;
      out_stall_i <= 1'b1;
      hold_left   <= HoldCycles;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned         phase;
    int unsigned         k;
    int unsigned         roll;
    logic [7:0]          alpha;
    pixel_in_t           px;
    abpp_pkg::abpp_cfg_t setting;

    directed_rows = '{
      known_row(8'hFF, 8'hFF, 8'hFF, 8'h00, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000),
      known_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0000_0000, 1'b1, 32'h00FF_FFFF),
      known_row(8'h12, 8'h34, 8'h56, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h0012_3456),
      known_row(8'h00, 8'h00, 8'h00, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000),
      pix_row(8'hFF, 8'h00, 8'hFF, 8'h01, 32'h00FF_00FF),
      pix_row(8'h00, 8'hFF, 8'h00, 8'hFE, 32'hFFFF_FFFF),
      pix_row(8'h80, 8'h7F, 8'h01, 8'h80, 32'hA5A5_A5A5),
      reg_row(abpp_pkg::REG_THREE_BYTE, 32'd1),
      known_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, 32'h00FF_FFFF),
      pix_row(8'h40, 8'hC0, 8'h20, 8'h64, 32'hFFFF_FFFF),
      reg_row(abpp_pkg::REG_RED_SHIFT, 32'd24),
      known_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0000_0000, 1'b1, 32'h0000_FFFF),
      reg_row(abpp_pkg::REG_THREE_BYTE, 32'd0),
      reg_row(abpp_pkg::REG_RED_BITS, 32'd0),
      reg_row(abpp_pkg::REG_GREEN_BITS, 32'd15),
      reg_row(abpp_pkg::REG_BLUE_SHIFT, 32'd31),
      pix_row(8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0000_0000),
      pix_row(8'h33, 8'h99, 8'hCC, 8'h9A, 32'hFFFF_FFFF),
      reg_row(abpp_pkg::REG_BLUE_BITS, 32'd3),
      reg_row(RegSpare, 32'hFFFF_FFFF),
      pix_row(8'h0A, 8'h0B, 8'h0C, 8'hC8, 32'h1234_5678)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_REG) begin
        drain_results();
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_pixel(directed_rows[i].px, directed_rows[i].known, directed_rows[i].want);
      end
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      drain_results();
      case (phase)
        0: setting = '{5'd16, 4'd8, 5'd8, 4'd8, 5'd0, 4'd8, 1'b0};
        1: setting = '{5'd11, 4'd5, 5'd5, 4'd6, 5'd0, 4'd5, 1'b0};
        2: setting = '{5'd31, 4'd8, 5'd31, 4'd8, 5'd31, 4'd8, 1'b0};
        3: setting = '{5'd0, 4'd0, 5'd0, 4'd0, 5'd0, 4'd0, 1'b0};
        4: setting = '{5'd0, 4'd15, 5'd4, 4'd15, 5'd8, 4'd15, 1'b1};
        5: setting = '{5'd24, 4'd8, 5'd12, 4'd4, 5'd0, 4'd1, 1'b1};
        default: begin
          setting.red_shift       = 5'($urandom);
          setting.red_bits        = chan_width();
          setting.green_shift     = 5'($urandom);
          setting.green_bits      = chan_width();
          setting.blue_shift      = 5'($urandom);
          setting.blue_bits       = chan_width();
          setting.three_byte_mode = 1'($urandom);
        end
      endcase
      write_reg(abpp_pkg::REG_RED_SHIFT,   pad_upper(32'(setting.red_shift), 5));
      write_reg(abpp_pkg::REG_RED_BITS,    pad_upper(32'(setting.red_bits), 4));
      write_reg(abpp_pkg::REG_GREEN_SHIFT, pad_upper(32'(setting.green_shift), 5));
      write_reg(abpp_pkg::REG_GREEN_BITS,  pad_upper(32'(setting.green_bits), 4));
      write_reg(abpp_pkg::REG_BLUE_SHIFT,  pad_upper(32'(setting.blue_shift), 5));
      write_reg(abpp_pkg::REG_BLUE_BITS,   pad_upper(32'(setting.blue_bits), 4));
      write_reg(abpp_pkg::REG_THREE_BYTE,  pad_upper(32'(setting.three_byte_mode), 1));
      if ($urandom_range(1) == 1) write_reg(RegSpare, $urandom());

      send_pct = (phase < 6) ? 35 : (phase < 12) ? 57 : 0;
      recv_pct = (phase < 6) ? 57 : (phase < 12) ? 35 : 0;
      // back-to-back transfers into a blocked output
      if (phase == 12) hold_wanted = 1'b1;

      for (k = 0; k < PhaseItems; k++) begin
        roll = $urandom_range(19);
        if (roll < 2) alpha = 8'd0;
        else if (roll < 5) alpha = abpp_pkg::AlphaFull;
        else if (roll == 5) alpha = ($urandom_range(1) == 1) ? 8'd1 : 8'd254;
        else alpha = 8'($urandom_range(254, 1));
        px = '{8'($urandom), 8'($urandom), 8'($urandom), alpha, $urandom()};
        send_pixel(px, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hdl/abpp_pkg.sv
hdl/abpp_cfg_regs.sv
hdl/alpha_blend_pixel_packer_top.sv
sim/tb.sv
